### design/wsta_pkg.sv
// shared types and constants for the weighted server task assigner
package wsta_pkg;

    // default sizing
    localparam int MAX_SERVERS_DEF = 16;
    localparam int TIME_BITS_DEF   = 40;

    // fixed field widths
    localparam int SLOT_W     = 4;
    localparam int WEIGHT_W   = 16;
    localparam int DUR_W      = 16;
    localparam int SERVER_W   = 4;
    localparam int OUT_TIME_W = 40;
    localparam int NOW_W      = 32;
    localparam int CFG_W      = 5;

    // active server count after reset
    localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

    // item kinds
    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_TASK = 1'b1
    } mode_t;

    // input item
    typedef struct packed {
        mode_t               mode;
        logic [SLOT_W-1:0]   server_slot;
        logic [WEIGHT_W-1:0] server_weight_in;
        logic [DUR_W-1:0]    task_duration;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [SERVER_W-1:0]   assigned_server;
        logic [OUT_TIME_W-1:0] start_second;
        logic [OUT_TIME_W-1:0] finish_second;
        logic                  had_to_wait;
    } out_item_t;

    // table update strobes
    typedef struct packed {
        logic load_we;
        logic task_we;
    } ctl_t;

endpackage

### design/wsta_state.sv
// server weight table, free time table and task second counter
module wsta_state #(
    parameter int MAX_SERVERS = wsta_pkg::MAX_SERVERS_DEF,
    parameter int TIME_BITS   = wsta_pkg::TIME_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  wsta_pkg::ctl_t                 ctl,
    input  logic [wsta_pkg::SLOT_W-1:0]    slot,
    input  logic [wsta_pkg::WEIGHT_W-1:0]  weight_in,
    input  logic [((MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1)-1:0] win_idx,
    input  logic [TIME_BITS-1:0]           finish,
    output logic [wsta_pkg::WEIGHT_W-1:0]  weight_q [MAX_SERVERS],
    output logic [TIME_BITS-1:0]           free_q [MAX_SERVERS],
    output logic [wsta_pkg::NOW_W-1:0]     now
);

    localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

    logic [wsta_pkg::WEIGHT_W-1:0] weight_reg [MAX_SERVERS];
    logic [TIME_BITS-1:0]          free_reg [MAX_SERVERS];
    logic [wsta_pkg::NOW_W-1:0]    now_reg;
    logic [wsta_pkg::NOW_W-1:0]    now_next;

    for (genvar j = 0; j < MAX_SERVERS; j++)
    begin : g_entry
        // weight load, slots past the table are dropped
        always_ff @(posedge clk)
        begin
            if (ctl.load_we && (32'(slot) == j))
            begin
                weight_reg[j] <= weight_in;
            end
        end

        // free time of the chosen server moves to its finish
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                free_reg[j] <= '0;
            end
            else if (ctl.task_we && (win_idx == IDX_W'(j)))
            begin
                free_reg[j] <= finish;
            end
        end

        assign weight_q[j] = weight_reg[j];
        assign free_q[j]   = free_reg[j];
    end

    // second counter steps once per task, wraps
    assign now_next = ctl.task_we ? now_reg + 1'b1 : now_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg <= '0;
        end
        else
        begin
            now_reg <= now_next;
        end
    end

    assign now = now_reg;

endmodule

### design/wsta_select.sv
// start time per server and min-key compare tree over (start, weight, index)
module wsta_select #(
    parameter int MAX_SERVERS = wsta_pkg::MAX_SERVERS_DEF,
    parameter int TIME_BITS   = wsta_pkg::TIME_BITS_DEF
) (
    input  logic [wsta_pkg::WEIGHT_W-1:0] weight_q [MAX_SERVERS],
    input  logic [TIME_BITS-1:0]          free_q [MAX_SERVERS],
    input  logic [wsta_pkg::NOW_W-1:0]    now,
    input  logic [wsta_pkg::CFG_W-1:0]    active_servers,
    output logic [((MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1)-1:0] win_idx,
    output logic [((TIME_BITS > wsta_pkg::NOW_W) ? TIME_BITS : wsta_pkg::NOW_W)-1:0] win_start
);

    localparam int IDX_W  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int KEY_W  = (TIME_BITS > wsta_pkg::NOW_W) ? TIME_BITS : wsta_pkg::NOW_W;
    localparam int LEVELS = $clog2(MAX_SERVERS);
    localparam int LEAVES = 1 << LEVELS;

    // heap-ordered tree nodes, leaves at LEAVES .. 2*LEAVES-1
    logic                          nd_valid  [1:2*LEAVES-1];
    logic [KEY_W-1:0]              nd_key    [1:2*LEAVES-1];
    logic [wsta_pkg::WEIGHT_W-1:0] nd_weight [1:2*LEAVES-1];
    logic [IDX_W-1:0]              nd_idx    [1:2*LEAVES-1];

    logic [KEY_W-1:0] now_ext;

    assign now_ext = KEY_W'(now);

    // leaves: start = max(free time, now), server 0 always in use
    for (genvar j = 0; j < LEAVES; j++)
    begin : g_leaf
        if (j < MAX_SERVERS)
        begin : g_real
            logic [KEY_W-1:0] free_ext;
            assign free_ext                = KEY_W'(free_q[j]);
            assign nd_valid[LEAVES + j]    = (j == 0) || (32'(j) < 32'(active_servers));
            assign nd_key[LEAVES + j]      = (free_ext > now_ext) ? free_ext : now_ext;
            assign nd_weight[LEAVES + j]   = weight_q[j];
            assign nd_idx[LEAVES + j]      = IDX_W'(j);
        end
        else
        begin : g_pad
            assign nd_valid[LEAVES + j]    = 1'b0;
            assign nd_key[LEAVES + j]      = '0;
            assign nd_weight[LEAVES + j]   = '0;
            assign nd_idx[LEAVES + j]      = '0;
        end
    end

    // inner nodes: right wins on smaller key, or tie and smaller weight
    for (genvar k = 1; k < LEAVES; k++)
    begin : g_node
        logic pick_r;
        assign pick_r = nd_valid[2*k+1] &&
                        (!nd_valid[2*k] ||
                         (nd_key[2*k+1] < nd_key[2*k]) ||
                         ((nd_key[2*k+1] == nd_key[2*k]) &&
                          (nd_weight[2*k+1] < nd_weight[2*k])));
        assign nd_valid[k]  = nd_valid[2*k] || nd_valid[2*k+1];
        assign nd_key[k]    = pick_r ? nd_key[2*k+1]    : nd_key[2*k];
        assign nd_weight[k] = pick_r ? nd_weight[2*k+1] : nd_weight[2*k];
        assign nd_idx[k]    = pick_r ? nd_idx[2*k+1]    : nd_idx[2*k];
    end

    assign win_idx   = nd_idx[1];
    assign win_start = nd_key[1];

endmodule

### design/weighted_server_task_assigner_top.sv
// top level of the weighted server task assigner
//
//  channel | signals                     | payload
//  --------+-----------------------------+-----------------------------
//  in      | in_valid / in_ready         | in_data  (wsta_pkg::in_item_t)
//  out     | out_valid / out_ready       | out_data (wsta_pkg::out_item_t)
//  cfg     | cfg_valid / cfg_ready       | cfg_data (active server count)
//
// one item per cycle while the output is not held: an item waits in the input
// register, the compare tree and finish add settle combinationally from it, and a
// task result lands in the output register as the task leaves the input register.
// loads give no result and never wait on the output side.
// a held output stalls only task items; the input register refills as it empties.
// reset clears all free times, the second counter and sets 16 active servers.
module weighted_server_task_assigner_top #(
    parameter int MAX_SERVERS = wsta_pkg::MAX_SERVERS_DEF,
    parameter int TIME_BITS   = wsta_pkg::TIME_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  wsta_pkg::in_item_t           in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output wsta_pkg::out_item_t          out_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [wsta_pkg::CFG_W-1:0]   cfg_data
);

    localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int KEY_W = (TIME_BITS > wsta_pkg::NOW_W) ? TIME_BITS : wsta_pkg::NOW_W;
    localparam int OW    = wsta_pkg::OUT_TIME_W;

    logic                         in_valid_reg;
    wsta_pkg::in_item_t           in_item_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    wsta_pkg::out_item_t          out_item_reg;
    logic [wsta_pkg::CFG_W-1:0]   active_reg;

    logic                         fire;
    wsta_pkg::ctl_t               ctl;

    logic [wsta_pkg::WEIGHT_W-1:0] weight_q [MAX_SERVERS];
    logic [TIME_BITS-1:0]          free_q [MAX_SERVERS];
    logic [wsta_pkg::NOW_W-1:0]    now;
    logic [IDX_W-1:0]              win_idx;
    logic [KEY_W-1:0]              win_start;

    logic [KEY_W:0]                finish_sum;
    logic [KEY_W:0]                time_max_ext;
    logic [KEY_W:0]                finish_key;
    logic [KEY_W+OW:0]             finish_wide;
    logic [KEY_W+OW-1:0]           start_wide;
    logic [IDX_W+wsta_pkg::SERVER_W-1:0] idx_wide;
    wsta_pkg::out_item_t           result;

    // config register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= wsta_pkg::ACTIVE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            active_reg <= cfg_data;
        end
    end

    // held item is processed when it is a load or the output can take a result
    assign fire = in_valid_reg &&
                  ((in_item_reg.mode == wsta_pkg::MODE_LOAD) || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    assign ctl.load_we = fire && (in_item_reg.mode == wsta_pkg::MODE_LOAD);
    assign ctl.task_we = fire && (in_item_reg.mode == wsta_pkg::MODE_TASK);

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
    end

    // tables
    wsta_state #(
        .MAX_SERVERS (MAX_SERVERS),
        .TIME_BITS   (TIME_BITS)
    ) u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .slot      (in_item_reg.server_slot),
        .weight_in (in_item_reg.server_weight_in),
        .win_idx   (win_idx),
        .finish    (finish_key[TIME_BITS-1:0]),
        .weight_q  (weight_q),
        .free_q    (free_q),
        .now       (now)
    );

    // server choice
    wsta_select #(
        .MAX_SERVERS (MAX_SERVERS),
        .TIME_BITS   (TIME_BITS)
    ) u_select (
        .weight_q       (weight_q),
        .free_q         (free_q),
        .now            (now),
        .active_servers (active_reg),
        .win_idx        (win_idx),
        .win_start      (win_start)
    );

    // finish = start + duration, saturating at the largest time
    assign finish_sum   = {1'b0, win_start} + (KEY_W + 1)'(in_item_reg.task_duration);
    assign time_max_ext = (KEY_W + 1)'({TIME_BITS{1'b1}});
    assign finish_key   = (finish_sum > time_max_ext) ? time_max_ext : finish_sum;

    // fit internal widths to the result fields
    assign finish_wide = {{OW{1'b0}}, finish_key};
    assign start_wide  = {{OW{1'b0}}, win_start};
    assign idx_wide    = {{wsta_pkg::SERVER_W{1'b0}}, win_idx};

    assign result.assigned_server = idx_wide[wsta_pkg::SERVER_W-1:0];
    assign result.start_second    = start_wide[OW-1:0];
    assign result.finish_second   = finish_wide[OW-1:0];
    assign result.had_to_wait     = win_start > KEY_W'(now);

    // output register
    assign out_valid_next = ctl.task_we ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.task_we)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

### design/wsta_checker.sv
// port-level checks for the weighted server task assigner, bound to the top
module wsta_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input wsta_pkg::out_item_t        out_data,
    input logic                       cfg_valid,
    input logic                       cfg_ready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // a task never finishes before it starts
    a_finish_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.finish_second >= out_data.start_second)
        else $error("finish earlier than start");

    // waiting means the start lies past second zero
    a_wait_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.had_to_wait |-> out_data.start_second != '0)
        else $error("wait flagged with start at zero");

    // config is always taken
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind weighted_server_task_assigner_top wsta_checker u_wsta_checker (.*);

### verif/weighted_server_task_assigner_top_test.sv
// self-checking testbench for the weighted server task assigner
module weighted_server_task_assigner_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS    = wsta_pkg::MAX_SERVERS_DEF;
    localparam int FREE_W       = wsta_pkg::TIME_BITS_DEF;
    localparam int PHASE_ITEMS  = 172;
    localparam int LONG_HOLDOFF = 300;
    localparam int SETTLE_CYCLES = 6;

    // clock, reset and block ports
    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    wsta_pkg::in_item_t            in_data   = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    wsta_pkg::out_item_t           out_data;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [wsta_pkg::CFG_W-1:0]    cfg_data  = '0;

    // predictor state
    logic [wsta_pkg::WEIGHT_W-1:0] server_weights [NUM_SLOTS];
    logic [FREE_W-1:0]             free_times [NUM_SLOTS];
    logic [wsta_pkg::NOW_W-1:0]    now_second;
    logic [wsta_pkg::CFG_W-1:0]    active_setting;

    // request feed and expected assignments
    wsta_pkg::in_item_t            pending_requests [$];
    wsta_pkg::out_item_t           expected_assignments [$];
    int                            requests_queued = 0;
    int                            requests_taken  = 0;
    int                            bad_assignments = 0;

    // idling controls
    bit                            src_gaps_en  = 1'b1;
    bit                            sink_gaps_en = 1'b1;
    int                            holdoff_left = 0;
    int                            send_gap     = 0;
    int                            sink_gap     = 0;

    weighted_server_task_assigner_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // task assignment: smallest (start, weight, index) among active servers
    function automatic void predict_assignment(wsta_pkg::in_item_t req);
        int                  count;
        int                  best;
        logic [FREE_W-1:0]   best_start;
        logic [FREE_W-1:0]   start;
        logic [FREE_W:0]     finish;
        logic [FREE_W-1:0]   now_wide;
        wsta_pkg::out_item_t res;
        if (req.mode == wsta_pkg::MODE_LOAD)
        begin
            server_weights[req.server_slot] = req.server_weight_in;
            return;
        end
        count = (active_setting == 0) ? 1 :
                (active_setting > NUM_SLOTS) ? NUM_SLOTS : int'(active_setting);
        now_wide = FREE_W'(now_second);
        best = 0;
        best_start = (free_times[0] > now_wide) ? free_times[0] : now_wide;
        for (int i = 1; i < count; i++)
        begin
            start = (free_times[i] > now_wide) ? free_times[i] : now_wide;
            if (start < best_start ||
                (start == best_start && server_weights[i] < server_weights[best]))
            begin
                best = i;
                best_start = start;
            end
        end
        // finish saturates at the top of the free time range
        finish = {1'b0, best_start} + (FREE_W+1)'(req.task_duration);
        if (finish[FREE_W])
            finish = {1'b0, {FREE_W{1'b1}}};
        free_times[best] = finish[FREE_W-1:0];
        res.assigned_server = wsta_pkg::SERVER_W'(best);
        res.start_second    = wsta_pkg::OUT_TIME_W'(best_start);
        res.finish_second   = wsta_pkg::OUT_TIME_W'(finish[FREE_W-1:0]);
        res.had_to_wait     = (best_start > now_wide);
        expected_assignments.push_back(res);
        now_second = now_second + 1'b1;
    endfunction

    function automatic wsta_pkg::in_item_t load_req(int slot,
                                                    logic [wsta_pkg::WEIGHT_W-1:0] weight);
        wsta_pkg::in_item_t it;
        it.mode             = wsta_pkg::MODE_LOAD;
        it.server_slot      = wsta_pkg::SLOT_W'(slot);
        it.server_weight_in = weight;
        it.task_duration    = wsta_pkg::DUR_W'($urandom);
        return it;
    endfunction

    function automatic wsta_pkg::in_item_t task_req(logic [wsta_pkg::DUR_W-1:0] dur);
        wsta_pkg::in_item_t it;
        it.mode             = wsta_pkg::MODE_TASK;
        it.server_slot      = wsta_pkg::SLOT_W'($urandom);
        it.server_weight_in = wsta_pkg::WEIGHT_W'($urandom);
        it.task_duration    = dur;
        return it;
    endfunction

    // random traffic: mostly tasks with short durations, some weight reloads
    function automatic wsta_pkg::in_item_t random_request();
        int r;
        int d;
        r = $urandom_range(99);
        if (r < 22)
        begin
            if ($urandom_range(1))
                return load_req($urandom_range(NUM_SLOTS - 1),
                                wsta_pkg::WEIGHT_W'($urandom_range(3)));
            return load_req($urandom_range(NUM_SLOTS - 1), wsta_pkg::WEIGHT_W'($urandom));
        end
        d = $urandom_range(99);
        if (d < 3)
            return task_req('0);
        if (d < 6)
            return task_req(wsta_pkg::DUR_W'($urandom));
        if (d < 70)
            return task_req(wsta_pkg::DUR_W'($urandom_range(8, 1)));
        return task_req(wsta_pkg::DUR_W'($urandom_range(40, 1)));
    endfunction

    task automatic queue_request(wsta_pkg::in_item_t it);
        pending_requests.push_back(it);
        requests_queued++;
    endtask

    // wait until every request is taken and every assignment has come back
    task automatic wait_drained();
        while (requests_taken != requests_queued || expected_assignments.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // one register write, only while the block is idle
    task automatic write_active_count(logic [wsta_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        active_setting = value;
        @(negedge clk);
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            // transfer at this edge feeds the predictor
            if (in_valid && in_ready)
            begin
                predict_assignment(in_data);
                requests_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    in_data  <= pending_requests.pop_front();
                    in_valid <= 1'b1;
                    send_gap = src_gaps_en ? pick_gap() : 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_assignments.size() == 0)
                begin
                    bad_assignments++;
                    if (bad_assignments <= 10)
                        $display({"unexpected result: server %0d start %0d",
                                  " finish %0d wait %0b"},
                                 out_data.assigned_server, out_data.start_second,
                                 out_data.finish_second, out_data.had_to_wait);
                end
                else
                begin
                    wsta_pkg::out_item_t want;
                    want = expected_assignments.pop_front();
                    if (out_data.assigned_server !== want.assigned_server ||
                        out_data.start_second    !== want.start_second ||
                        out_data.finish_second   !== want.finish_second ||
                        out_data.had_to_wait     !== want.had_to_wait)
                    begin
                        bad_assignments++;
                        if (bad_assignments <= 10)
                            $display({"mismatch: expected server %0d start %0d",
                                      " finish %0d wait %0b, got server %0d",
                                      " start %0d finish %0d wait %0b"},
                                     want.assigned_server, want.start_second,
                                     want.finish_second, want.had_to_wait,
                                     out_data.assigned_server, out_data.start_second,
                                     out_data.finish_second, out_data.had_to_wait);
                    end
                end
                if (sink_gaps_en)
                    sink_gap = pick_gap();
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                out_ready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    // stimulus sequence
    initial
    begin
        logic [wsta_pkg::CFG_W-1:0] settings [8];
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            server_weights[i] = '0;
            free_times[i]     = '0;
        end
        now_second     = '0;
        active_setting = wsta_pkg::ACTIVE_RESET;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: load every weight first, extremes and ties among them
        queue_request(load_req(0, 16'hFFFF));
        queue_request(load_req(1, 16'h0000));
        queue_request(load_req(2, 16'h0000));
        queue_request(load_req(3, 16'h8000));
        for (int i = 4; i < NUM_SLOTS - 1; i++)
            queue_request(load_req(i, wsta_pkg::WEIGHT_W'((i % 2) ? 16'h5555 + i
                                                                  : 16'hAAAA - i)));
        queue_request(load_req(NUM_SLOTS - 1, 16'h0001));
        // zero duration leaves the server free, then shortest and longest
        queue_request(task_req(16'h0000));
        queue_request(task_req(16'h0000));
        queue_request(task_req(16'h0001));
        queue_request(task_req(16'hFFFF));
        queue_request(task_req(16'h5555));
        queue_request(task_req(16'hAAAA));
        queue_request(task_req(16'h0002));
        wait_drained();

        // settings: single server, zero and oversized counts, full pool, random
        settings[0] = 5'd1;
        settings[1] = 5'd0;
        settings[2] = 5'd31;
        settings[3] = 5'd16;
        settings[4] = wsta_pkg::CFG_W'($urandom_range(15, 2));
        settings[5] = wsta_pkg::CFG_W'($urandom_range(30, 17));
        settings[6] = wsta_pkg::CFG_W'($urandom_range(15, 2));
        settings[7] = 5'd16;

        for (int p = 0; p < 8; p++)
        begin
            write_active_count(settings[p]);
            src_gaps_en  = (p % 4 == 1) || (p % 4 == 2);
            sink_gaps_en = (p % 4 == 2) || (p % 4 == 3);
            // long receiver hold-off while the sender keeps offering
            if (p == 0 || p == 4)
                holdoff_left = LONG_HOLDOFF;
            for (int k = 0; k < PHASE_ITEMS; k++)
                queue_request(random_request());
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (bad_assignments == 0 && expected_assignments.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
design/wsta_pkg.sv
design/wsta_state.sv
design/wsta_select.sv
design/weighted_server_task_assigner_top.sv
design/wsta_checker.sv
verif/weighted_server_task_assigner_top_test.sv
